@@ src/hash_bucket_store_lookup_top_macros.svh @@
// Assertion macros shared by the hash bucket RTL.
// Clocked on clk, disabled while arst_n is low; no other dependencies.
`ifndef HASH_BUCKET_STORE_LOOKUP_TOP_MACROS_SVH
`define HASH_BUCKET_STORE_LOOKUP_TOP_MACROS_SVH

// Check a property on every rising edge of clk outside reset.
`define HBSL_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check that a condition never holds outside reset.
`define HBSL_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

@@ src/hbsl_pkg.sv @@
// Package for the hash bucket store/lookup block: sizes, entry layout, helpers.
// No dependencies.
`timescale 1ns / 1ps

package hbsl_pkg;

	localparam int WAYS       = 4;
	localparam int AGE_LEVELS = 8;
	localparam int DATA_WIDTH = 64;

	localparam int KEY_WIDTH  = 64;
	localparam int AGE_WIDTH  = 3;
	localparam int SLOT_WIDTH = 2;
	localparam int WAY_W      = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int ENTRY_W    = KEY_WIDTH + AGE_WIDTH + DATA_WIDTH;

	localparam logic [WAY_W:0] WAYS_L = (WAY_W + 1)'(WAYS);

	typedef logic [WAY_W-1:0] way_t;

	typedef struct packed {
		logic [KEY_WIDTH-1:0]  key;
		logic [AGE_WIDTH-1:0]  age;
		logic [DATA_WIDTH-1:0] data;
	} entry_t;

	// Bring a sum below 2*WAYS back into the bucket.
	function automatic way_t wrap_f(input logic [WAY_W:0] v);
		logic [WAY_W:0] r;
		r = (v >= WAYS_L) ? (v - WAYS_L) : v;
		return r[WAY_W-1:0];
	endfunction

	// Reduce a request age into the range of age levels.
	function automatic logic [AGE_WIDTH-1:0] age_reduce_f(input logic [AGE_WIDTH-1:0] v);
		logic [8:0] r;
		r = {6'b0, v};
		for (int i = 0; i < 8; i++) begin
			if (r >= 9'(AGE_LEVELS)) begin
				r = r - 9'(AGE_LEVELS);
			end
		end
		return r[AGE_WIDTH-1:0];
	endfunction

endpackage

@@ src/hbsl_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; no package.
`timescale 1ns / 1ps

module hbsl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic                             clk,
	input  logic                             we,
	input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
	input  logic [WIDTH-1:0]                 wdata,
	input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
	output logic [WIDTH-1:0]                 rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

@@ src/hash_bucket_store_lookup_top.sv @@
// Hash table bucket with rotating lookup and age-based replacement on store.
// Uses hbsl_pkg, hbsl_ram and hash_bucket_store_lookup_top_macros.svh.
//
// Usage:
//   Requests enter on in_valid/in_ready with req_type (0 lookup, 1 store), key,
//   entry_age and entry_data. One result leaves per request on
//   out_valid/out_ready with hit, data_out, age_out and slot.
//   The block works on one request at a time. The bucket sits in one RAM
//   with a registered read; a scan streams one slot per cycle starting at
//   the last accessed slot. A lookup ends on the first key match or after
//   the last slot; a store on a key match writes that slot in place, else a
//   victim walk of one slot per cycle from the slot after the last access
//   picks the first free or stale-age slot, or falls back to that slot.
//   Reset clears all valid marks and the last-access pointer; the RAM needs
//   no clearing pass since entries without a valid mark are never read out.
//   A stalled receiver holds the result in the output register; the next
//   request is taken meanwhile and its result waits until the register frees.
`timescale 1ns / 1ps

module hash_bucket_store_lookup_top (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic                           req_type,
	input  logic [hbsl_pkg::KEY_WIDTH-1:0]  key,
	input  logic [hbsl_pkg::AGE_WIDTH-1:0]  entry_age,
	input  logic [hbsl_pkg::DATA_WIDTH-1:0] entry_data,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic                           hit,
	output logic [hbsl_pkg::DATA_WIDTH-1:0] data_out,
	output logic [hbsl_pkg::AGE_WIDTH-1:0]  age_out,
	output logic [hbsl_pkg::SLOT_WIDTH-1:0] slot
);

	import hbsl_pkg::*;

	`include "hash_bucket_store_lookup_top_macros.svh"

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_VICTIM,
		ST_WRITE,
		ST_RESP
	} state_t;

	state_t state_q;

	// Latched request
	logic                  req_type_q;
	logic [KEY_WIDTH-1:0]  key_q;
	logic [AGE_WIDTH-1:0]  age_q;
	logic [DATA_WIDTH-1:0] data_q;

	// Bucket control state
	logic [WAYS-1:0] valid_q;
	logic [WAYS-1:0] diff_q;
	way_t            last_q;
	logic [WAY_W:0]  iss_q;
	way_t            vic_q;
	way_t            wslot_q;

	// Check stage, in the cycle after the RAM read address is issued
	logic chk_vld_s1;
	way_t chk_slot_s1;
	logic chk_last_s1;

	// Pending result
	logic                  res_hit_q;
	logic [DATA_WIDTH-1:0] res_data_q;
	logic [AGE_WIDTH-1:0]  res_age_q;
	way_t                  res_slot_q;

	// RAM
	logic   ram_we;
	way_t   ram_waddr;
	entry_t ram_wdata;
	way_t   ram_raddr;
	logic [ENTRY_W-1:0] ram_rbits;
	entry_t rd;

	logic issuing;
	logic match_now;
	way_t vslot;
	way_t next_slot;

	assign in_ready  = (state_q == ST_IDLE);
	assign issuing   = (state_q == ST_SCAN) && (iss_q < WAYS_L);
	assign ram_raddr = wrap_f({1'b0, last_q} + iss_q);
	assign rd        = entry_t'(ram_rbits);
	assign match_now = chk_vld_s1 && valid_q[chk_slot_s1] && (rd.key == key_q);
	assign next_slot = wrap_f({1'b0, last_q} + (WAY_W + 1)'(1));
	assign vslot     = wrap_f({1'b0, last_q} + (WAY_W + 1)'(1) + {1'b0, vic_q});

	assign ram_we    = (state_q == ST_WRITE);
	assign ram_waddr = wslot_q;
	assign ram_wdata = '{key: key_q, age: age_q, data: data_q};

	hbsl_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (WAYS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rbits)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			valid_q     <= '0;
			last_q      <= '0;
			iss_q       <= '0;
			vic_q       <= '0;
			chk_vld_s1  <= 1'b0;
			out_valid   <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				out_valid <= 1'b0;
			end
			chk_vld_s1 <= 1'b0;

			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						req_type_q <= req_type;
						key_q      <= key;
						age_q      <= age_reduce_f(entry_age);
						data_q     <= entry_data;
						iss_q      <= '0;
						state_q    <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (issuing) begin
						iss_q <= iss_q + (WAY_W + 1)'(1);
					end
					chk_vld_s1  <= issuing && !match_now;
					chk_slot_s1 <= ram_raddr;
					chk_last_s1 <= (iss_q == WAYS_L - (WAY_W + 1)'(1));
					if (chk_vld_s1) begin
						diff_q[chk_slot_s1] <= !valid_q[chk_slot_s1] || (rd.age != age_q);
					end
					if (match_now) begin
						chk_vld_s1 <= 1'b0;
						if (req_type_q) begin
							wslot_q <= chk_slot_s1;
							state_q <= ST_WRITE;
						end else begin
							res_hit_q  <= 1'b1;
							res_data_q <= rd.data;
							res_age_q  <= rd.age;
							res_slot_q <= chk_slot_s1;
							last_q     <= chk_slot_s1;
							state_q    <= ST_RESP;
						end
					end else if (chk_vld_s1 && chk_last_s1) begin
						if (req_type_q) begin
							vic_q   <= '0;
							state_q <= ST_VICTIM;
						end else begin
							res_hit_q  <= 1'b0;
							res_data_q <= '0;
							res_age_q  <= '0;
							res_slot_q <= last_q;
							state_q    <= ST_RESP;
						end
					end
				end
				ST_VICTIM: begin
					// Walk from the slot after the last access; fall back to that slot
					if (diff_q[vslot]) begin
						wslot_q <= vslot;
						state_q <= ST_WRITE;
					end else if (vic_q == way_t'(WAYS - 1)) begin
						wslot_q <= next_slot;
						state_q <= ST_WRITE;
					end else begin
						vic_q <= vic_q + way_t'(1);
					end
				end
				ST_WRITE: begin
					valid_q[wslot_q] <= 1'b1;
					last_q           <= wslot_q;
					res_hit_q        <= 1'b1;
					res_data_q       <= '0;
					res_age_q        <= '0;
					res_slot_q       <= wslot_q;
					state_q          <= ST_RESP;
				end
				ST_RESP: begin
					// Hold until the output register is free
					if (!out_valid || out_ready) begin
						out_valid <= 1'b1;
						hit       <= res_hit_q;
						data_out  <= res_data_q;
						age_out   <= res_age_q;
						slot      <= SLOT_WIDTH'(res_slot_q);
						state_q   <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	`HBSL_ASSERT(a_one_request, in_valid && in_ready |=> !in_ready, "second request taken while busy")
	`HBSL_ASSERT(a_write_store, ram_we |-> req_type_q, "RAM written on a lookup")
	`HBSL_ASSERT(a_write_marks, ram_we |=> valid_q[$past(ram_waddr)], "written slot not marked valid")
	`HBSL_ASSERT(a_load_resp, $rose(out_valid) |-> $past(state_q == ST_RESP), "result loaded outside response")
	`HBSL_NEVER(a_check_scan, chk_vld_s1 && (state_q != ST_SCAN), "check stage live outside scan")

endmodule

@@ test/hbsl_bucket_checker.sv @@
// Scoreboard for the hash bucket store/lookup block, plus the request codes shared
// with the testbench top. It predicts each result from a private copy of the bucket.
// Depends on hbsl_pkg.
`timescale 1ns / 1ps

package hbsl_tb_pkg;

	typedef enum logic {
		REQ_LOOKUP = 1'b0,
		REQ_STORE  = 1'b1
	} req_kind_e;

endpackage

module hbsl_bucket_checker
	import hbsl_pkg::*;
	import hbsl_tb_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic                  in_ready,
	input  logic                  req_type,
	input  logic [KEY_WIDTH-1:0]  key,
	input  logic [AGE_WIDTH-1:0]  entry_age,
	input  logic [DATA_WIDTH-1:0] entry_data,
	input  logic                  out_valid,
	input  logic                  out_ready,
	input  logic                  hit,
	input  logic [DATA_WIDTH-1:0] data_out,
	input  logic [AGE_WIDTH-1:0]  age_out,
	input  logic [SLOT_WIDTH-1:0] slot,
	output int                    fail_count,
	output int                    pending_results
);

	typedef struct packed {
		logic                  hit;
		logic [DATA_WIDTH-1:0] data;
		logic [AGE_WIDTH-1:0]  age;
		logic [SLOT_WIDTH-1:0] slot;
	} bucket_result_t;

	logic [KEY_WIDTH-1:0]  way_key  [WAYS];
	logic [DATA_WIDTH-1:0] way_data [WAYS];
	logic [AGE_WIDTH-1:0]  way_age  [WAYS];
	logic                  way_live [WAYS];
	way_t                  last_way;

	bucket_result_t result_q [$];

	// Apply one request to the bucket copy and return the result it should produce.
	function automatic bucket_result_t predict_access(req_kind_e op, logic [KEY_WIDTH-1:0] k,
			logic [AGE_WIDTH-1:0] a, logic [DATA_WIDTH-1:0] d);
		bucket_result_t r;
		logic [AGE_WIDTH-1:0] age_n;
		way_t s;
		way_t pick;
		bit found;
		r = '0;
		found = 1'b0;
		pick = last_way;
		age_n = AGE_WIDTH'(int'(a) % AGE_LEVELS);
		if (op == REQ_LOOKUP) begin
			for (int i = 0; i < WAYS; i++) begin
				s = way_t'((int'(last_way) + i) % WAYS);
				if (!found && way_live[s] && way_key[s] == k) begin
					found = 1'b1;
					last_way = s;
					r.hit = 1'b1;
					r.data = way_data[s];
					r.age = way_age[s];
				end
			end
			r.slot = last_way;
			return r;
		end
		r.hit = 1'b1;
		for (int i = 0; i < WAYS; i++) begin
			s = way_t'((int'(last_way) + i) % WAYS);
			if (!found && way_live[s] && way_key[s] == k) begin
				found = 1'b1;
				pick = s;
			end
		end
		// no key match: take the first free or stale-age way after the last one touched
		for (int i = 0; i < WAYS; i++) begin
			s = way_t'((int'(last_way) + 1 + i) % WAYS);
			if (!found && (!way_live[s] || way_age[s] != age_n)) begin
				found = 1'b1;
				pick = s;
			end
		end
		if (!found)
			pick = way_t'((int'(last_way) + 1) % WAYS);
		way_key[pick] = k;
		way_data[pick] = d;
		way_age[pick] = age_n;
		way_live[pick] = 1'b1;
		last_way = pick;
		r.slot = pick;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		bucket_result_t got;
		bucket_result_t want;
		if (!arst_n) begin
			for (int i = 0; i < WAYS; i++) begin
				way_key[i] = '0;
				way_data[i] = '0;
				way_age[i] = '0;
				way_live[i] = 1'b0;
			end
			last_way = '0;
			result_q.delete();
			fail_count = 0;
			pending_results = 0;
		end else begin
			if (out_valid && out_ready) begin
				got = {hit, data_out, age_out, slot};
				if (result_q.size() == 0) begin
					$error("result with nothing outstanding: hit %0d data %h age %0d slot %0d",
						got.hit, got.data, got.age, got.slot);
					fail_count++;
				end else begin
					want = result_q.pop_front();
					if (got.hit !== want.hit) begin
						$error("hit: expected %0d, got %0d", want.hit, got.hit);
						fail_count++;
					end
					if (got.data !== want.data) begin
						$error("data_out: expected %h, got %h", want.data, got.data);
						fail_count++;
					end
					if (got.age !== want.age) begin
						$error("age_out: expected %0d, got %0d", want.age, got.age);
						fail_count++;
					end
					if (got.slot !== want.slot) begin
						$error("slot: expected %0d, got %0d", want.slot, got.slot);
						fail_count++;
					end
				end
			end
			if (in_valid && in_ready)
				result_q.push_back(predict_access(req_kind_e'(req_type), key, entry_age,
					entry_data));
			pending_results = result_q.size();
		end
	end

endmodule

@@ test/hash_bucket_store_lookup_top_test.sv @@
// Testbench top for hash_bucket_store_lookup_top: clock, reset, request stimulus and
// result back-pressure; hbsl_bucket_checker does prediction and comparison.
// Depends on hbsl_pkg, hbsl_tb_pkg and hbsl_bucket_checker.
`timescale 1ns / 1ps

module hash_bucket_store_lookup_top_test;
	import hbsl_pkg::*;
	import hbsl_tb_pkg::*;

	localparam int CYCLE_LIMIT   = 400000;
	localparam int PHASE_ITEMS   = 160;
	localparam int POOL_SIZE     = 6;
	localparam int DRAIN_CYCLES  = 16;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	logic                  req_type = 1'b0;
	logic [KEY_WIDTH-1:0]  key = '0;
	logic [AGE_WIDTH-1:0]  entry_age = '0;
	logic [DATA_WIDTH-1:0] entry_data = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic                  hit;
	logic [DATA_WIDTH-1:0] data_out;
	logic [AGE_WIDTH-1:0]  age_out;
	logic [SLOT_WIDTH-1:0] slot;

	int fail_count;
	int pending_results;
	int sender_idle_pct = 0;
	int recv_stall_pct = 0;

	logic [KEY_WIDTH-1:0] key_pool [POOL_SIZE];
	logic [KEY_WIDTH-1:0] dir_key  [6];

	hash_bucket_store_lookup_top DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.req_type   (req_type),
		.key        (key),
		.entry_age  (entry_age),
		.entry_data (entry_data),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.hit        (hit),
		.data_out   (data_out),
		.age_out    (age_out),
		.slot       (slot)
	);

	hbsl_bucket_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.req_type        (req_type),
		.key             (key),
		.entry_age       (entry_age),
		.entry_data      (entry_data),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.hit             (hit),
		.data_out        (data_out),
		.age_out         (age_out),
		.slot            (slot),
		.fail_count      (fail_count),
		.pending_results (pending_results)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(negedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// Present one request and hold it until the handshake completes.
	task automatic send_req(req_kind_e op, logic [KEY_WIDTH-1:0] k, logic [AGE_WIDTH-1:0] a,
			logic [DATA_WIDTH-1:0] d);
		while ($urandom_range(99) < sender_idle_pct) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
		@(negedge clk);
		in_valid <= 1'b1;
		req_type <= op;
		key <= k;
		entry_age <= a;
		entry_data <= d;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	initial begin
		int cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("hash_bucket_store_lookup_top_test: done, errors");
		$finish;
	end

	initial begin
		logic [AGE_WIDTH-1:0] generation;
		logic [KEY_WIDTH-1:0] k;
		logic [AGE_WIDTH-1:0] a;
		req_kind_e op;
		for (int i = 0; i < 6; i++)
			dir_key[i] = rand64();
		for (int i = 0; i < POOL_SIZE; i++)
			key_pool[i] = rand64();
		generation = '0;

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// empty bucket: key zero must not match a way that was never written
		send_req(REQ_LOOKUP, '0, '0, '0);
		send_req(REQ_STORE, '0, 3'd0, '0);
		send_req(REQ_LOOKUP, '0, 3'd7, '1);
		send_req(REQ_STORE, '1, 3'd7, '1);
		send_req(REQ_LOOKUP, '1, '0, '0);
		// same key again: overwrite in place
		send_req(REQ_STORE, '0, 3'd5, 64'hA5A5_5A5A_F00F_0FF0);
		send_req(REQ_LOOKUP, '0, '0, '0);
		// fill every way with one age, then store a new key of that age
		for (int i = 0; i < 4; i++)
			send_req(REQ_STORE, dir_key[i], 3'd3, rand64());
		send_req(REQ_STORE, dir_key[4], 3'd3, rand64());
		send_req(REQ_LOOKUP, dir_key[4], '0, '0);
		send_req(REQ_LOOKUP, '1, '0, '0);
		send_req(REQ_LOOKUP, dir_key[0], '0, '0);
		send_req(REQ_STORE, dir_key[1], 3'd4, rand64());
		send_req(REQ_STORE, dir_key[5], 3'd3, rand64());
		send_req(REQ_LOOKUP, dir_key[1], '0, '0);
		send_req(REQ_LOOKUP, dir_key[5], 3'd7, '1);
		send_req(REQ_LOOKUP, rand64(), AGE_WIDTH'(rand64()), rand64());
		send_req(REQ_STORE, dir_key[2], 3'd7, '1);
		send_req(REQ_LOOKUP, dir_key[2], '0, '0);

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin
					sender_idle_pct = 0;
					recv_stall_pct = 0;
				end
				1: begin
					sender_idle_pct = 60;
					recv_stall_pct = 0;
				end
				2: begin
					sender_idle_pct = 0;
					recv_stall_pct = 60;
				end
				default: begin
					sender_idle_pct = 25;
					recv_stall_pct = 25;
				end
			endcase
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				// rotate the key set now and then so lookups keep missing too
				if (n % 40 == 39)
					key_pool[$urandom_range(POOL_SIZE - 1)] = rand64();
				if ($urandom_range(9) == 0)
					generation = generation + 1'b1;
				k = ($urandom_range(99) < 75) ? key_pool[$urandom_range(POOL_SIZE - 1)]
					: rand64();
				a = ($urandom_range(99) < 75) ? generation : AGE_WIDTH'($urandom_range(7));
				op = ($urandom_range(1) == 1) ? REQ_STORE : REQ_LOOKUP;
				send_req(op, k, a, rand64());
			end
		end

		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_results != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (fail_count == 0)
			$display("hash_bucket_store_lookup_top_test: done, clean");
		else
			$display("hash_bucket_store_lookup_top_test: done, errors");
		$finish;
	end

endmodule

@@ filelist.f @@
+incdir+src
src/hbsl_pkg.sv
src/hbsl_ram.sv
src/hash_bucket_store_lookup_top.sv
test/hbsl_bucket_checker.sv
test/hash_bucket_store_lookup_top_test.sv
